### sv/sensor_dropout_recovery_timer_defines.svh
// Assertion macros used by the sensor dropout recovery timer checker.
`ifndef SENSOR_DROPOUT_RECOVERY_TIMER_DEFINES_SVH
`define SENSOR_DROPOUT_RECOVERY_TIMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdrt check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdrt check failed");

`endif

### sv/sdrt_pkg.sv
// Shared types and constants for the sensor dropout recovery timer.
package sdrt_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAUSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH_NEEDED = 1'd1;

  localparam logic [31:0] MAX_PAUSE_RST = 32'd1000;
  localparam logic [7:0] FRESH_NEEDED_RST = 8'd3;

  typedef enum logic [1:0] {
    DEC_CONTINUE  = 2'd0,
    DEC_PAUSED    = 2'd1,
    DEC_RECOVERED = 2'd2,
    DEC_TIMEOUT   = 2'd3
  } decision_t;

  typedef struct packed {
    logic [31:0] max_pause_ms;
    logic [7:0]  fresh_needed;
  } cfg_t;

  typedef struct packed {
    logic               sensor_ready;
    logic [31:0]        good_read_total;
    logic signed [15:0] heading;
    logic               heading_finite;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    decision_t          decision;
    logic               pause_began;
    logic [30:0]        timer_adjust_ms;
    logic [30:0]        pause_elapsed;
    logic signed [15:0] held_heading;
    logic [31:0]        paused_total;
    logic [31:0]        pauses_seen;
    logic               recovering;
  } result_t;

endpackage

### sv/sdrt_cfg.sv
// Configuration registers of the sensor dropout recovery timer.
module sdrt_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sdrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdrt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output sdrt_pkg::cfg_t                     cfg
);

  logic [31:0] max_pause_r, max_pause_nxt;
  logic [7:0]  fresh_needed_r, fresh_needed_nxt;

  always_comb begin
    max_pause_nxt = max_pause_r;
    fresh_needed_nxt = fresh_needed_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sdrt_pkg::CFG_MAX_PAUSE: max_pause_nxt = cfg_wdata[31:0];
        sdrt_pkg::CFG_FRESH_NEEDED: fresh_needed_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pause_r <= sdrt_pkg::MAX_PAUSE_RST;
      fresh_needed_r <= sdrt_pkg::FRESH_NEEDED_RST;
    end else begin
      max_pause_r <= max_pause_nxt;
      fresh_needed_r <= fresh_needed_nxt;
    end
  end

  assign cfg.max_pause_ms = max_pause_r;
  assign cfg.fresh_needed = fresh_needed_r;

endmodule

### sv/sdrt_core.sv
// Pause tracking state and the per-tick decision logic.
module sdrt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sdrt_pkg::item_t   item,
  input  sdrt_pkg::cfg_t    cfg,
  output sdrt_pkg::result_t res
);

  logic               active_r, active_nxt;
  logic signed [15:0] heading_r, heading_nxt;
  logic [31:0]        start_r, start_nxt;
  logic [31:0]        last_svc_r, last_svc_nxt;
  logic [31:0]        last_reads_r, last_reads_nxt;
  logic [7:0]         fresh_run_r, fresh_run_nxt;
  logic [31:0]        tally_r, tally_nxt;
  logic [31:0]        sum_r, sum_nxt;

  logic [31:0] adj_diff;
  logic [31:0] el_diff;
  logic [30:0] adj;
  logic [30:0] elapsed;
  logic [32:0] sum_wide;
  logic [7:0]  fresh_inc;
  logic        cfg_bad;

  always_comb begin
    active_nxt = active_r;
    heading_nxt = heading_r;
    start_nxt = start_r;
    last_svc_nxt = last_svc_r;
    last_reads_nxt = last_reads_r;
    fresh_run_nxt = fresh_run_r;
    tally_nxt = tally_r;
    sum_nxt = sum_r;

    adj_diff = item.now_ms - last_svc_r;
    el_diff = item.now_ms - start_r;
    adj = adj_diff[31] ? 31'd0 : adj_diff[30:0];
    elapsed = el_diff[31] ? 31'd0 : el_diff[30:0];
    sum_wide = {1'b0, sum_r} + {2'b00, adj};
    fresh_inc = ((item.good_read_total != last_reads_r) && (fresh_run_r != 8'hFF)) ?
                fresh_run_r + 8'd1 : fresh_run_r;
    cfg_bad = (cfg.max_pause_ms == 32'd0) || (cfg.fresh_needed == 8'd0);

    res.decision = sdrt_pkg::DEC_CONTINUE;
    res.pause_began = 1'b0;
    res.timer_adjust_ms = 31'd0;
    res.pause_elapsed = 31'd0;

    if (cfg_bad) begin
      res.decision = sdrt_pkg::DEC_TIMEOUT;
    end else if (!active_r) begin
      if (!item.sensor_ready) begin
        active_nxt = 1'b1;
        heading_nxt = item.heading_finite ? item.heading : 16'sd0;
        start_nxt = item.now_ms;
        last_svc_nxt = item.now_ms;
        last_reads_nxt = item.good_read_total;
        fresh_run_nxt = 8'd0;
        tally_nxt = tally_r + 32'd1;
        res.decision = sdrt_pkg::DEC_PAUSED;
        res.pause_began = 1'b1;
      end
    end else begin
      res.timer_adjust_ms = adj;
      res.pause_elapsed = elapsed;
      last_svc_nxt = item.now_ms;
      sum_nxt = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
      if ({1'b0, elapsed} >= cfg.max_pause_ms) begin
        active_nxt = 1'b0;
        fresh_run_nxt = 8'd0;
        res.decision = sdrt_pkg::DEC_TIMEOUT;
      end else begin
        last_reads_nxt = item.good_read_total;
        if (!item.sensor_ready) begin
          fresh_run_nxt = 8'd0;
          res.decision = sdrt_pkg::DEC_PAUSED;
        end else begin
          fresh_run_nxt = fresh_inc;
          if (fresh_inc < cfg.fresh_needed) begin
            res.decision = sdrt_pkg::DEC_PAUSED;
          end else begin
            active_nxt = 1'b0;
            res.decision = sdrt_pkg::DEC_RECOVERED;
          end
        end
      end
    end

    res.held_heading = heading_nxt;
    res.paused_total = sum_nxt;
    res.pauses_seen = tally_nxt;
    res.recovering = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      heading_r <= 16'sd0;
      start_r <= 32'd0;
      last_svc_r <= 32'd0;
      last_reads_r <= 32'd0;
      fresh_run_r <= 8'd0;
      tally_r <= 32'd0;
      sum_r <= 32'd0;
    end else if (fire) begin
      active_r <= active_nxt;
      heading_r <= heading_nxt;
      start_r <= start_nxt;
      last_svc_r <= last_svc_nxt;
      last_reads_r <= last_reads_nxt;
      fresh_run_r <= fresh_run_nxt;
      tally_r <= tally_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

### sv/sensor_dropout_recovery_timer.sv
// Top level of the sensor dropout recovery timer.
// A transferred input is held in the input register until it can advance into the result register.
// Throughput: one item per cycle while the output is not stalled; the input register feeds the decision logic,
// which updates the pause state and loads the result register in the same cycle.
// Reset (synchronous, active low) clears the pause state and both handshake stages
// and restores the configuration registers to their defaults.
module sensor_dropout_recovery_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_sensor_ready,
  input  logic [31:0]                     in_good_read_total,
  input  logic signed [15:0]              in_heading,
  input  logic                            in_heading_finite,
  input  logic [31:0]                     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_decision,
  output logic                            out_pause_began,
  output logic [30:0]                     out_timer_adjust_ms,
  output logic [30:0]                     out_pause_elapsed,
  output logic signed [15:0]              out_held_heading,
  output logic [31:0]                     out_paused_total,
  output logic [31:0]                     out_pauses_seen,
  output logic                            out_recovering,
  input  logic                            cfg_we,
  input  logic [sdrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sdrt_pkg::cfg_t    cfg;
  sdrt_pkg::item_t   item_r, item_nxt;
  sdrt_pkg::result_t res;
  sdrt_pkg::result_t res_r;
  logic              in_full_r, in_full_nxt;
  logic              out_full_r, out_full_nxt;
  logic              in_xfer;
  logic              advance;

  sdrt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdrt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance = in_full_r && (!out_full_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    item_nxt.sensor_ready = in_sensor_ready;
    item_nxt.good_read_total = in_good_read_total;
    item_nxt.heading = in_heading;
    item_nxt.heading_finite = in_heading_finite;
    item_nxt.now_ms = in_now_ms;

    in_full_nxt = in_full_r;
    if (in_xfer) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end

    out_full_nxt = out_full_r;
    if (advance) begin
      out_full_nxt = 1'b1;
    end else if (!out_stall) begin
      out_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = out_full_r;
  assign out_decision = res_r.decision;
  assign out_pause_began = res_r.pause_began;
  assign out_timer_adjust_ms = res_r.timer_adjust_ms;
  assign out_pause_elapsed = res_r.pause_elapsed;
  assign out_held_heading = res_r.held_heading;
  assign out_paused_total = res_r.paused_total;
  assign out_pauses_seen = res_r.pauses_seen;
  assign out_recovering = res_r.recovering;

endmodule

### sv/sdrt_checker.sv
// Port-level checks for the sensor dropout recovery timer, bound to the top level.
`include "sensor_dropout_recovery_timer_defines.svh"

module sdrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_decision,
  input logic                            out_pause_began,
  input logic [30:0]                     out_timer_adjust_ms,
  input logic [30:0]                     out_pause_elapsed,
  input logic [31:0]                     out_paused_total,
  input logic                            out_recovering
);

  `SDRT_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && out_stall, out_valid)
  `SDRT_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_valid && out_stall, $stable(out_decision) && $stable(out_paused_total))
  `SDRT_ASSERT_NOW(a_began_is_entry, clk, rst_n, out_valid && out_pause_began, (out_decision == sdrt_pkg::DEC_PAUSED) && out_recovering && (out_timer_adjust_ms == 31'd0) && (out_pause_elapsed == 31'd0))
  `SDRT_ASSERT_NOW(a_recovering_means_paused, clk, rst_n, out_valid && (out_decision != sdrt_pkg::DEC_TIMEOUT), out_recovering == (out_decision == sdrt_pkg::DEC_PAUSED))

endmodule

bind sensor_dropout_recovery_timer sdrt_checker u_sdrt_checker (.*);
